### hdl/lphm_pkg.sv
`default_nettype none
package lphm_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_INSERTED  = 3'd0,
		STAT_UPDATED   = 3'd1,
		STAT_REMOVED   = 3'd2,
		STAT_FOUND     = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_FULL      = 3'd5,
		STAT_CLEARED   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_LIVE    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	typedef struct packed {
		mark_t       mark;
		logic [63:0] key;
		logic [31:0] data;
	} slot_t;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam int          LIVE_W    = 11;

endpackage
`default_nettype wire

### hdl/linear_probe_hash_map.sv
`default_nettype none
// Channel  Dir  Handshake        Payload
// s_axis   in   tvalid/tready    tdata: key, value_in; tuser: kind
// m_axis   out  tvalid/tready    tdata: status, value_out, live_count
//
// One item at a time: FNV-1a over KEY_BYTES key bytes (one byte and one multiply
// per cycle), then the table read starts, then the slots are probed in turn
// (the read of the next slot overlaps the check of the current one), then the
// output register is loaded. Clear sweeps every slot of the table.
// After reset the same sweep runs before the first item is taken.
// A new item is taken while a result still waits on m_axis.
module linear_probe_hash_map
	import lphm_pkg::*;
#(
	parameter int SLOTS     = 1024,
	parameter int KEY_BYTES = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [95:0]  s_axis_tdata,   // key [63:0], value_in [95:64]
	input  wire logic [1:0]   s_axis_tuser,   // kind [1:0]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [47:0]       m_axis_tdata    // status [2:0], value_out [34:3],
	                                          // live_count [45:35], zero [47:46]
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS) + 1;
	localparam int BYTE_W = $clog2(KEY_BYTES);
	localparam int HALF   = SLOTS / 2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_LOOK,
		S_PROBE,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    n_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                clr_res_q;
	logic [CNT_W-1:0]    live_q;
	logic [CNT_W-1:0]    adds_q;
	status_t             res_stat_q;
	logic [31:0]         res_vout_q;
	logic [CNT_W-1:0]    res_live_q;

	kind_t               kind_q;
	logic [63:0]         key_q;
	logic [63:0]         hk_q;
	logic [31:0]         val_q;
	logic [31:0]         hash_q;

	slot_t               slot_mem [SLOTS];
	slot_t               rd_q;
	logic [IDX_W-1:0]    rd_addr;

	logic                mem_we;
	slot_t               mem_wd;
	logic                hit;
	logic                empty;
	logic                probe_end;
	status_t             stat_n;
	logic [31:0]         vout_n;
	logic [CNT_W-1:0]    live_n;
	logic [CNT_W-1:0]    adds_n;
	logic                accept;
	logic [CNT_W+LIVE_W-1:0] live_ext;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign live_ext      = {{LIVE_W{1'b0}}, res_live_q};

	// Probe check, clear sweep and write-back of the slot under test
	always_comb begin
		hit       = (rd_q.mark == MARK_LIVE) && (rd_q.key == key_q);
		empty     = (rd_q.mark == MARK_EMPTY);
		probe_end = hit || empty || (&n_q);
		mem_we    = 1'b0;
		mem_wd    = rd_q;
		stat_n    = STAT_NOT_FOUND;
		vout_n    = '0;
		live_n    = live_q;
		adds_n    = adds_q;
		rd_addr   = (state_q == S_LOOK) ? hash_q[IDX_W-1:0] : IDX_W'(idx_q + 1'b1);
		case (state_q)
			S_CLEAR: begin
				mem_we      = 1'b1;
				mem_wd.mark = MARK_EMPTY;
			end
			S_PROBE: begin
				if (probe_end) begin
					case (kind_q)
						KIND_INSERT: begin
							if (hit) begin
								mem_we      = 1'b1;
								mem_wd.data = val_q;
								stat_n      = STAT_UPDATED;
							end else if (adds_q > CNT_W'(HALF) || !empty) begin
								stat_n = STAT_FULL;
							end else begin
								mem_we      = 1'b1;
								mem_wd.mark = MARK_LIVE;
								mem_wd.key  = key_q;
								mem_wd.data = val_q;
								live_n      = CNT_W'(live_q + 1'b1);
								adds_n      = CNT_W'(adds_q + 1'b1);
								stat_n      = STAT_INSERTED;
							end
						end
						KIND_REMOVE: begin
							if (hit) begin
								mem_we      = 1'b1;
								mem_wd.mark = MARK_DELETED;
								if (live_q != '0)
									live_n = CNT_W'(live_q - 1'b1);
								stat_n = STAT_REMOVED;
							end
						end
						KIND_LOOKUP: begin
							if (hit) begin
								vout_n = rd_q.data;
								stat_n = STAT_FOUND;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			slot_mem[idx_q] <= mem_wd;
		rd_q <= slot_mem[rd_addr];
	end

	// Operand and hash registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(s_axis_tuser);
			key_q  <= s_axis_tdata[63:0];
			hk_q   <= s_axis_tdata[63:0];
			val_q  <= s_axis_tdata[95:64];
			hash_q <= FNV_BASIS;
		end else if (state_q == S_HASH) begin
			hash_q <= 32'((hash_q ^ {24'd0, hk_q[7:0]}) * FNV_PRIME);
			hk_q   <= {8'd0, hk_q[63:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			idx_q         <= '0;
			n_q           <= '0;
			byte_q        <= '0;
			clr_res_q     <= 1'b0;
			live_q        <= '0;
			adds_q        <= '0;
			res_stat_q    <= STAT_CLEARED;
			res_vout_q    <= '0;
			res_live_q    <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (state_q == S_DONE && (!m_axis_tvalid || m_axis_tready))
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					idx_q <= IDX_W'(idx_q + 1'b1);
					if (&idx_q) begin
						live_q <= '0;
						adds_q <= '0;
						if (clr_res_q) begin
							res_stat_q <= STAT_CLEARED;
							res_vout_q <= '0;
							res_live_q <= '0;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (kind_t'(s_axis_tuser) == KIND_CLEAR) begin
							idx_q     <= '0;
							clr_res_q <= 1'b1;
							state_q   <= S_CLEAR;
						end else begin
							byte_q  <= '0;
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					byte_q <= BYTE_W'(byte_q + 1'b1);
					if (byte_q == BYTE_W'(KEY_BYTES - 1))
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					idx_q   <= hash_q[IDX_W-1:0];
					n_q     <= '0;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (probe_end) begin
						live_q     <= live_n;
						adds_q     <= adds_n;
						res_stat_q <= stat_n;
						res_vout_q <= vout_n;
						res_live_q <= live_n;
						state_q    <= S_DONE;
					end else begin
						idx_q <= IDX_W'(idx_q + 1'b1);
						n_q   <= IDX_W'(n_q + 1'b1);
					end
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tdata  <= {2'b00, live_ext[LIVE_W-1:0], res_vout_q, res_stat_q};
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
module tb;
	import lphm_pkg::*;

	localparam int SLOT_COUNT  = 1024;
	localparam int IDLE_LIMIT  = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_OPS  = 1060;

	typedef struct {
		status_t     status;
		logic [31:0] value;
		logic [10:0] live;
	} map_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;    // key [63:0], value_in [95:64]
	logic [1:0]  s_axis_tuser = '0;    // kind [1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;         // status [2:0], value_out [34:3], live_count [45:35]

	linear_probe_hash_map dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// shadow copy of the table
	logic [63:0] tbl_key [SLOT_COUNT];
	logic [31:0] tbl_val [SLOT_COUNT];
	mark_t       tbl_mark [SLOT_COUNT];
	int          live_cnt = 0;
	int          adds_cnt = 0;

	map_result_t expected_results [$];
	logic [63:0] key_pool [$];
	logic [63:0] filled_keys [$];
	int          errors = 0;
	int          send_calm = 0;
	int          ready_calm = 0;
	int          idle_cycles = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;

	function automatic int home_of(logic [63:0] key);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < 8; i++) begin
			h = h ^ {24'd0, key[8*i +: 8]};
			h = h * FNV_PRIME;
		end
		return int'(h & (SLOT_COUNT - 1));
	endfunction

	function automatic bit probe_slot(input logic [63:0] key, output int at,
			output int empty_at);
		int idx;
		idx = home_of(key);
		at = 0;
		empty_at = SLOT_COUNT;
		for (int n = 0; n < SLOT_COUNT; n++) begin
			if (tbl_mark[idx] == MARK_EMPTY) begin
				empty_at = idx;
				return 1'b0;
			end
			if (tbl_mark[idx] == MARK_LIVE && tbl_key[idx] == key) begin
				at = idx;
				return 1'b1;
			end
			idx = (idx + 1) % SLOT_COUNT;
		end
		return 1'b0;
	endfunction

	// apply one accepted operation to the shadow table and queue its result
	task automatic apply_op(kind_t kind, logic [63:0] key, logic [31:0] val);
		map_result_t r;
		int at;
		int empty_at;
		bit hit;
		r.status = STAT_NOT_FOUND;
		r.value = '0;
		if (kind == KIND_CLEAR) begin
			foreach (tbl_mark[i])
				tbl_mark[i] = MARK_EMPTY;
			live_cnt = 0;
			adds_cnt = 0;
			r.status = STAT_CLEARED;
		end else begin
			hit = probe_slot(key, at, empty_at);
			case (kind)
				KIND_INSERT: begin
					if (hit) begin
						tbl_val[at] = val;
						r.status = STAT_UPDATED;
					end else if (adds_cnt > SLOT_COUNT / 2 || empty_at >= SLOT_COUNT) begin
						r.status = STAT_FULL;
					end else begin
						tbl_key[empty_at] = key;
						tbl_val[empty_at] = val;
						tbl_mark[empty_at] = MARK_LIVE;
						live_cnt++;
						adds_cnt++;
						r.status = STAT_INSERTED;
					end
				end
				KIND_REMOVE: begin
					if (hit) begin
						tbl_mark[at] = MARK_DELETED;
						if (live_cnt > 0)
							live_cnt--;
						r.status = STAT_REMOVED;
					end
				end
				default: begin
					if (hit) begin
						r.value = tbl_val[at];
						r.status = STAT_FOUND;
					end
				end
			endcase
		end
		r.live = live_cnt[10:0];
		expected_results.push_back(r);
	endtask

	// mostly short gaps, a few long ones, now and then a run with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(10, 50);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] collider_of(logic [63:0] key);
		logic [63:0] c;
		do
			c = {$urandom, $urandom};
		while (home_of(c) != home_of(key) || c == key);
		return c;
	endfunction

	// drive one beat and hold it until accepted; tvalid stays high if no gap follows
	task automatic send_op(kind_t kind, logic [63:0] key, logic [31:0] val);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {val, key};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		apply_op(kind, key, val);
	endtask

	task automatic send_random_op();
		int pick;
		logic [63:0] key;
		pick = $urandom_range(0, 99);
		key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (pick < 2)
			send_op(KIND_CLEAR, {$urandom, $urandom}, $urandom);
		else if (pick < 37)
			send_op(KIND_INSERT, key, $urandom);
		else if (pick < 57)
			send_op(KIND_REMOVE, key, $urandom);
		else if (pick < 87)
			send_op(KIND_LOOKUP, key, $urandom);
		else
			send_op(kind_t'($urandom_range(0, 2)), {$urandom, $urandom}, $urandom);
	endtask

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	task automatic test_basic_ops();
		send_op(KIND_CLEAR, '0, '0);
		send_op(KIND_LOOKUP, '0, '1);
		send_op(KIND_REMOVE, '1, '0);
		send_op(KIND_INSERT, '0, '0);
		send_op(KIND_INSERT, '1, '1);
		send_op(KIND_LOOKUP, '0, '1);
		send_op(KIND_LOOKUP, '1, '0);
		send_op(KIND_INSERT, '1, 32'h5a5a_a5a5);
		send_op(KIND_LOOKUP, '1, '0);
		send_op(KIND_REMOVE, '0, '1);
		send_op(KIND_LOOKUP, '0, '0);
		send_op(KIND_REMOVE, '0, '0);
		send_op(KIND_INSERT, '0, '1);
		send_op(KIND_LOOKUP, '0, '0);
		send_op(KIND_CLEAR, {$urandom, $urandom}, $urandom);
		send_op(KIND_LOOKUP, '1, '1);
	endtask

	// two keys on one home slot: probe past a live slot, then past a tombstone
	task automatic test_probe_collisions();
		logic [63:0] first_key;
		logic [63:0] second_key;
		first_key = {$urandom, $urandom};
		second_key = collider_of(first_key);
		send_op(KIND_INSERT, first_key, $urandom);
		send_op(KIND_INSERT, second_key, $urandom);
		send_op(KIND_LOOKUP, second_key, $urandom);
		send_op(KIND_REMOVE, first_key, $urandom);
		send_op(KIND_LOOKUP, second_key, $urandom);
		send_op(KIND_INSERT, first_key, $urandom);
		send_op(KIND_LOOKUP, first_key, $urandom);
		send_op(KIND_CLEAR, '0, '0);
	endtask

	task automatic test_fill_to_full();
		logic [63:0] key;
		send_op(KIND_CLEAR, '0, '0);
		filled_keys.delete();
		while (adds_cnt <= SLOT_COUNT / 2) begin
			key = {$urandom, $urandom};
			send_op(KIND_INSERT, key, $urandom);
			filled_keys.push_back(key);
		end
		repeat (4)
			send_op(KIND_INSERT, {$urandom, $urandom}, $urandom);
		send_op(KIND_INSERT, filled_keys[0], $urandom);
		send_op(KIND_LOOKUP, filled_keys[0], $urandom);
		for (int i = 1; i <= 3; i++)
			send_op(KIND_REMOVE, filled_keys[i], $urandom);
		send_op(KIND_LOOKUP, filled_keys[1], $urandom);
		// removals do not lower the add count, so a new key is still refused
		send_op(KIND_INSERT, filled_keys[1], $urandom);
		send_op(KIND_INSERT, filled_keys[4], $urandom);
		repeat (10)
			send_op(KIND_LOOKUP, filled_keys[$urandom_range(0, filled_keys.size() - 1)],
				$urandom);
		send_op(KIND_CLEAR, '1, '1);
	endtask

	task automatic test_random_mix();
		logic [63:0] base;
		key_pool.delete();
		key_pool.push_back('0);
		key_pool.push_back('1);
		repeat (12) begin
			base = {$urandom, $urandom};
			key_pool.push_back(base);
			repeat (3)
				key_pool.push_back(collider_of(base));
		end
		repeat (RANDOM_OPS)
			send_random_op();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (30)
			send_random_op();
	endtask

	initial begin : stimulus
		foreach (tbl_mark[i])
			tbl_mark[i] = MARK_EMPTY;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_probe_collisions();
		test_fill_to_full();
		test_random_mix();
		test_backpressure();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("linear_probe_hash_map regression: pass");
		else
			$display("linear_probe_hash_map regression: fail");
		$finish;
	end

	initial begin : result_ready
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				stall = pick_gap(ready_calm);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		map_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat, status", '0, 32'(m_axis_tdata[2:0]));
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[2:0] !== want.status)
					report_mismatch("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
				if (m_axis_tdata[34:3] !== want.value)
					report_mismatch("value_out", want.value, m_axis_tdata[34:3]);
				if (m_axis_tdata[45:35] !== want.live)
					report_mismatch("live_count", 32'(want.live), 32'(m_axis_tdata[45:35]));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("linear_probe_hash_map regression: fail");
				$finish;
			end
		end
	end

endmodule
